@@ design/long_write_reassembly_top_macros.svh @@
// ---------------------------------------------------------------------------
// Long write reassembly assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ---------------------------------------------------------------------------
`ifndef LONG_WRITE_REASSEMBLY_TOP_MACROS_SVH
`define LONG_WRITE_REASSEMBLY_TOP_MACROS_SVH

// same-cycle implication
`define LWR_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("long write reassembly: assertion failed");

// next-cycle implication
`define LWR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("long write reassembly: assertion failed");

`endif

@@ design/lwr_pkg.sv @@
// ---------------------------------------------------------------------------
// Long write reassembly package
// Codes, widths and shared types of the reassembly block.
// ---------------------------------------------------------------------------
package lwr_pkg;

  localparam int IDX_W = 6;
  localparam int LEN_W = 7;
  localparam int PADDR_W = 3;

  localparam logic [PADDR_W-1:0] ADDR_HANDLE_CFG = 3'd0;

  localparam logic CMD_PREPARE = 1'b0;
  localparam logic CMD_EXECUTE = 1'b1;

  localparam logic [1:0] STATUS_REJECTED = 2'd0;
  localparam logic [1:0] STATUS_ACCEPTED = 2'd1;
  localparam logic [1:0] STATUS_READY    = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_WRITE,
    ST_RD_ADDR,
    ST_RD_DATA
  } lwr_state_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [7:0]       wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } lwr_mem_req_t;

endpackage

@@ design/long_write_reassembly_top.sv @@
// ---------------------------------------------------------------------------
// Long write reassembly top level
// Gathers prepare fragments into a byte-wide frame store and releases the
// frame byte by byte on execute commit.
// ---------------------------------------------------------------------------
// A word is taken only while the block is idle, then judged in ST_EVAL. A good
// prepare fragment then writes its payload into the frame store, one byte a
// cycle. Execute with commit reads the frame back byte by byte, each byte
// first addressed in ST_RD_ADDR and then handed out from the registered read
// data in ST_RD_DATA. Stalls on the master side hold the sequencer while it
// waits to hand a word out. The store needs no clearing pass after reset.
module long_write_reassembly_top #(
  parameter int FRAME_BYTES    = 64,
  parameter int FRAGMENT_BYTES = 18
) (
  input  logic                        clk,
  input  logic                        rst,
  // slave side
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // target_handle, fragment_offset, payload_length, payload_low, payload_mid,
  // payload_high
  input  logic [183:0]                s_tdata,
  // command, commit
  input  logic [1:0]                  s_tuser,
  // master side
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // frame_byte, byte_index, frame_length, zero fill
  output logic [23:0]                 m_tdata,
  // status
  output logic [1:0]                  m_tuser,
  output logic                        m_tlast,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lwr_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int AW    = $clog2(FRAME_BYTES);
  localparam int PAY_W = FRAGMENT_BYTES * 8;
  localparam int CNT_W = $clog2(FRAGMENT_BYTES + 1);

  lwr_pkg::lwr_state_t state, state_next;

  logic [15:0]                 handle_cfg;
  logic                        session_active;
  logic [15:0]                 session_handle;
  logic [lwr_pkg::LEN_W-1:0]   gathered_length;

  logic                        cmd;
  logic                        commit;
  logic [15:0]                 handle;
  logic [15:0]                 offset;
  logic [7:0]                  length;
  logic [PAY_W-1:0]            payload;
  logic [CNT_W-1:0]            remaining;
  logic [lwr_pkg::IDX_W-1:0]   wr_addr;
  logic [lwr_pkg::IDX_W-1:0]   rd_index;

  logic [143:0]                payload_in;
  logic [7:0]                  room;
  logic                        prep_reject;
  logic                        exec_reject;
  logic                        out_free;
  logic                        rd_last;
  logic [7:0]                  rd_data;
  lwr_pkg::lwr_mem_req_t       req;

  logic                        push;
  logic [1:0]                  push_status;
  logic                        push_last;

  logic                        out_ready_word;
  logic                        ready_fields_ok;
  logic                        store_fits;

  assign payload_in = s_tdata[183:40];
  assign out_free   = !m_tvalid || m_tready;
  assign room       = 8'(FRAME_BYTES) - {1'b0, gathered_length};

  assign prep_reject = (handle_cfg == 16'd0) || (handle != handle_cfg) ||
                       (length == 8'd0) || (length > 8'(FRAGMENT_BYTES)) ||
                       (offset != {9'd0, gathered_length}) ||
                       (session_active && (session_handle != handle)) ||
                       (length > room);
  assign exec_reject = !session_active || (gathered_length == '0);
  assign rd_last     = ({1'b0, rd_index} + 7'd1) == gathered_length;

  // configuration
  assign pready = 1'b1;
  assign prdata = {16'd0, handle_cfg};

  always_ff @(posedge clk) begin
    if (rst) begin
      handle_cfg <= '0;
    end else if (psel && penable && pwrite && (paddr == lwr_pkg::ADDR_HANDLE_CFG)) begin
      handle_cfg <= pwdata[15:0];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      lwr_pkg::ST_IDLE: begin
        if (s_tvalid) state_next = lwr_pkg::ST_EVAL;
      end
      lwr_pkg::ST_EVAL: begin
        if (cmd == lwr_pkg::CMD_PREPARE) begin
          if (out_free) state_next = prep_reject ? lwr_pkg::ST_IDLE : lwr_pkg::ST_WRITE;
        end else if (exec_reject || !commit) begin
          if (out_free) state_next = lwr_pkg::ST_IDLE;
        end else begin
          state_next = lwr_pkg::ST_RD_ADDR;
        end
      end
      lwr_pkg::ST_WRITE: begin
        if (remaining == CNT_W'(1)) state_next = lwr_pkg::ST_IDLE;
      end
      lwr_pkg::ST_RD_ADDR: begin
        state_next = lwr_pkg::ST_RD_DATA;
      end
      lwr_pkg::ST_RD_DATA: begin
        if (out_free) state_next = rd_last ? lwr_pkg::ST_IDLE : lwr_pkg::ST_RD_ADDR;
      end
      default: state_next = lwr_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_tready    = 1'b0;
    push        = 1'b0;
    push_status = lwr_pkg::STATUS_REJECTED;
    push_last   = 1'b1;
    req.we      = 1'b0;
    req.waddr   = wr_addr;
    req.wdata   = payload[7:0];
    req.re      = 1'b0;
    req.raddr   = rd_index;
    unique case (state)
      lwr_pkg::ST_IDLE: begin
        s_tready = 1'b1;
      end
      lwr_pkg::ST_EVAL: begin
        if (cmd == lwr_pkg::CMD_PREPARE) begin
          push        = out_free;
          push_status = prep_reject ? lwr_pkg::STATUS_REJECTED : lwr_pkg::STATUS_ACCEPTED;
        end else if (exec_reject) begin
          push        = out_free;
          push_status = lwr_pkg::STATUS_REJECTED;
        end else if (!commit) begin
          push        = out_free;
          push_status = lwr_pkg::STATUS_ACCEPTED;
        end
      end
      lwr_pkg::ST_WRITE: begin
        req.we = 1'b1;
      end
      lwr_pkg::ST_RD_ADDR: begin
        req.re = 1'b1;
      end
      lwr_pkg::ST_RD_DATA: begin
        push        = out_free;
        push_status = lwr_pkg::STATUS_READY;
        push_last   = rd_last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lwr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // session and item registers
  always_ff @(posedge clk) begin
    if (rst) begin
      session_active  <= 1'b0;
      session_handle  <= '0;
      gathered_length <= '0;
    end else begin
      unique case (state)
        lwr_pkg::ST_EVAL: begin
          if (out_free && (cmd == lwr_pkg::CMD_PREPARE)) begin
            if (prep_reject) begin
              session_active  <= 1'b0;
              session_handle  <= '0;
              gathered_length <= '0;
            end else begin
              session_active  <= 1'b1;
              session_handle  <= handle;
              gathered_length <= gathered_length + length[lwr_pkg::LEN_W-1:0];
            end
          end else if (out_free && (exec_reject || !commit)) begin
            session_active  <= 1'b0;
            session_handle  <= '0;
            gathered_length <= '0;
          end
        end
        lwr_pkg::ST_RD_DATA: begin
          if (out_free && rd_last) begin
            session_active  <= 1'b0;
            session_handle  <= '0;
            gathered_length <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      cmd     <= s_tuser[0];
      commit  <= s_tuser[1];
      handle  <= s_tdata[15:0];
      offset  <= s_tdata[31:16];
      length  <= s_tdata[39:32];
      payload <= payload_in[PAY_W-1:0];
    end else if (state == lwr_pkg::ST_WRITE) begin
      payload <= payload >> 8;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      lwr_pkg::ST_EVAL: begin
        wr_addr   <= gathered_length[lwr_pkg::IDX_W-1:0];
        remaining <= length[CNT_W-1:0];
        rd_index  <= '0;
      end
      lwr_pkg::ST_WRITE: begin
        wr_addr   <= wr_addr + 1'b1;
        remaining <= remaining - 1'b1;
      end
      lwr_pkg::ST_RD_DATA: begin
        if (out_free) rd_index <= rd_index + 1'b1;
      end
      default: ;
    endcase
  end

  lwr_store #(
    .DEPTH (FRAME_BYTES),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (push) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      m_tuser <= push_status;
      m_tlast <= push_last;
      if (push_status == lwr_pkg::STATUS_READY) begin
        m_tdata <= {3'd0, gathered_length, rd_index, rd_data};
      end else begin
        m_tdata <= '0;
      end
    end
  end

  assign out_ready_word  = m_tvalid && (m_tuser == lwr_pkg::STATUS_READY);
  assign ready_fields_ok = (m_tdata[20:14] != 7'd0) &&
                           ({1'b0, m_tdata[13:8]} < m_tdata[20:14]);
  assign store_fits      = session_active && (gathered_length <= 7'(FRAME_BYTES));

`include "long_write_reassembly_top_macros.svh"

  `LWR_ASSERT_IMPL(a_ready_in_frame, out_ready_word, ready_fields_ok)
  `LWR_ASSERT_IMPL(a_write_in_session, state == lwr_pkg::ST_WRITE, store_fits)
  `LWR_ASSERT_NEXT(a_read_follows_addr, state == lwr_pkg::ST_RD_ADDR, state == lwr_pkg::ST_RD_DATA)
  `LWR_ASSERT_IMPL(a_idle_no_length, !session_active, gathered_length == 7'd0)

endmodule

@@ design/lwr_store.sv @@
// ---------------------------------------------------------------------------
// Long write reassembly frame store
// Byte-wide synchronous memory, one write and one registered read per cycle.
// ---------------------------------------------------------------------------
module lwr_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                 clk,
  input  lwr_pkg::lwr_mem_req_t req,
  output logic [7:0]           rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr[AW-1:0]] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data <= mem[req.raddr[AW-1:0]];
    end
  end

endmodule
